/* hdl/lnedit_pkg.sv */
`default_nettype none

package lnedit_pkg;

  // Special characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Input operation codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ECHO       = 2'd0;
  localparam logic [1:0] KIND_LINE_BYTE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY_READ = 2'd2;
  localparam logic [1:0] KIND_NOT_READY  = 2'd3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int COUNT_W     = 7;

  // Controller to datapath
  typedef struct packed {
    logic capture;      // latch the accepted input transaction
    logic store;        // append the character to the line
    logic len_dec;      // remove the last character
    logic start;        // clear step/index counters, latch read length
    logic echo_load;    // load an echo result
    logic status_load;  // load an empty-read or not-ready result
    logic rd_en;        // read line store at the drain index
    logic drain_load;   // load a line byte result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_read;
    logic line_pending;
    logic is_nl;
    logic is_bs;
    logic len_zero;
    logic room;         // an ordinary character still fits
    logic n_zero;       // read would deliver nothing
    logic echo_last;
    logic drain_last;
    logic out_free;     // output register can take a new result
  } stat_t;

endpackage

`default_nettype wire

/* hdl/lnedit_dp.sv */
`default_nettype none

module lnedit_dp #(
  parameter int LINE_DEPTH = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire  [lnedit_pkg::IN_TDATA_W-1:0] in_data,
  input  wire                               in_op,
  input  wire  lnedit_pkg::cmd_t            cmd,
  output lnedit_pkg::stat_t                 st,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_data,
  output logic                              out_last,
  output logic [lnedit_pkg::COUNT_W-1:0]    out_count
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);
  localparam int CW = (LW > lnedit_pkg::COUNT_W) ? LW : lnedit_pkg::COUNT_W;
  localparam logic [LW-1:0] DEPTH_L    = LW'(LINE_DEPTH);
  localparam logic [LW-1:0] DEPTH_M1_L = LW'(LINE_DEPTH - 1);

  logic [7:0]    line_store [LINE_DEPTH];
  logic [7:0]    rdata;
  logic          op;
  logic [7:0]    char_q;
  logic [15:0]   maxb;
  logic [LW-1:0] line_length;
  logic          line_pending;
  logic [LW-1:0] n_len;
  logic [LW-1:0] idx;
  logic [1:0]    step;

  logic [LW-1:0] n_calc;
  logic [LW-1:0] idx_next;
  logic [CW-1:0] count_wide;
  logic          len_lt_depth;
  logic          mem_we;
  logic          clear_line;
  logic [7:0]    echo_data;

  assign len_lt_depth = line_length < DEPTH_L;
  assign mem_we       = cmd.store && len_lt_depth;
  assign n_calc       = (maxb < 16'(line_length)) ? maxb[LW-1:0] : line_length;
  assign idx_next     = idx + LW'(1);
  assign count_wide   = CW'(idx) + CW'(1);
  assign clear_line   = (cmd.status_load && line_pending) ||
                        (cmd.drain_load && st.drain_last);

  always_comb begin
    if (st.is_bs) begin
      echo_data = (step == 2'd1) ? lnedit_pkg::CH_SPACE : lnedit_pkg::CH_BACKSPACE;
    end else begin
      echo_data = char_q;
    end
  end

  always_comb begin
    st.op_read      = (op == lnedit_pkg::OP_READ);
    st.line_pending = line_pending;
    st.is_nl        = (char_q == lnedit_pkg::CH_NEWLINE);
    st.is_bs        = (char_q == lnedit_pkg::CH_BACKSPACE);
    st.len_zero     = (line_length == '0);
    st.room         = line_length < DEPTH_M1_L;
    st.n_zero       = (n_calc == '0);
    st.echo_last    = !st.is_bs || (step == 2'd2);
    st.drain_last   = (idx_next == n_len);
    st.out_free     = !out_valid || out_ready;
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[line_length[AW-1:0]] <= char_q;
    end
    if (cmd.rd_en) begin
      rdata <= line_store[idx[AW-1:0]];
    end
  end

  // Input capture and counters
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= in_op;
      char_q <= in_data[7:0];
      maxb   <= in_data[23:8];
    end
    if (cmd.start) begin
      n_len <= n_calc;
      idx   <= '0;
      step  <= '0;
    end else begin
      if (cmd.drain_load) begin
        idx <= idx_next;
      end
      if (cmd.echo_load) begin
        step <= step + 2'd1;
      end
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      line_pending <= 1'b0;
    end else begin
      if (clear_line) begin
        line_length  <= '0;
        line_pending <= 1'b0;
      end else begin
        if (mem_we) begin
          line_length <= line_length + LW'(1);
        end else if (cmd.len_dec) begin
          line_length <= line_length - LW'(1);
        end
        if (cmd.store && st.is_nl) begin
          line_pending <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.echo_load || cmd.status_load || cmd.drain_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.echo_load) begin
      out_kind  <= lnedit_pkg::KIND_ECHO;
      out_data  <= echo_data;
      out_last  <= st.echo_last;
      out_count <= '0;
    end else if (cmd.status_load) begin
      out_kind  <= line_pending ? lnedit_pkg::KIND_EMPTY_READ : lnedit_pkg::KIND_NOT_READY;
      out_data  <= '0;
      out_last  <= 1'b1;
      out_count <= '0;
    end else if (cmd.drain_load) begin
      out_kind  <= lnedit_pkg::KIND_LINE_BYTE;
      out_data  <= rdata;
      out_last  <= st.drain_last;
      out_count <= count_wide[lnedit_pkg::COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/lnedit_ctrl.sv */
`default_nettype none

module lnedit_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire lnedit_pkg::stat_t st,
  output lnedit_pkg::cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_ECHO   = 6'b000100,
    S_STATUS = 6'b001000,
    S_READ   = 6'b010000,
    S_SEND   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.start = 1'b1;
        if (!st.op_read) begin
          if (st.line_pending) begin
            // drop characters while a line waits to be read
            state_next = S_IDLE;
          end else if (st.is_nl) begin
            cmd.store  = 1'b1;
            state_next = S_ECHO;
          end else if (st.is_bs) begin
            if (st.len_zero) begin
              state_next = S_IDLE;
            end else begin
              cmd.len_dec = 1'b1;
              state_next  = S_ECHO;
            end
          end else if (st.room) begin
            cmd.store  = 1'b1;
            state_next = S_ECHO;
          end else begin
            state_next = S_IDLE;
          end
        end else if (!st.line_pending || st.n_zero) begin
          state_next = S_STATUS;
        end else begin
          state_next = S_READ;
        end
      end
      S_ECHO: begin
        if (st.out_free) begin
          cmd.echo_load = 1'b1;
          if (st.echo_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_STATUS: begin
        if (st.out_free) begin
          cmd.status_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (st.out_free) begin
          cmd.drain_load = 1'b1;
          state_next     = st.drain_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/line_editor_with_echo.sv */
// Sequence: a transaction is captured, then decoded; an echo or status result is then
//   registered from S_ECHO or S_STATUS, a line byte from S_SEND, held by any output stall.
// A new transaction is taken only in S_IDLE, after the last one is through; a read drains
//   each line byte through S_READ then S_SEND, set by the line store's registered read port.
// Reset (synchronous, active high) empties the line, clears the ready flag, the
//   controller and the output valid; line store contents are left as they are.
`default_nettype none

module line_editor_with_echo #(
  parameter int LINE_DEPTH = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [lnedit_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // char_in, max_bytes
  input  wire                                s_axis_tuser,   // operation
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [lnedit_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // data, returned_count, pad
  output logic                               m_axis_tlast,
  output logic [1:0]                         m_axis_tuser    // kind
);

  lnedit_pkg::cmd_t  cmd;
  lnedit_pkg::stat_t st;

  logic [7:0]                       out_data;
  logic [lnedit_pkg::COUNT_W-1:0]   out_count;

  lnedit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lnedit_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_op     (s_axis_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (out_data),
    .out_last  (m_axis_tlast),
    .out_count (out_count)
  );

  assign m_axis_tdata = {1'b0, out_count, out_data};

  // One item at a time: no new transaction right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous item in decode");

  // Results are loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.echo_load || cmd.status_load || cmd.drain_load) |-> st.out_free)
    else $error("result loaded over a pending result");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == lnedit_pkg::KIND_NOT_READY ||
                       m_axis_tuser == lnedit_pkg::KIND_EMPTY_READ))
    |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("status result with nonzero payload or without last");

  a_echo_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == lnedit_pkg::KIND_ECHO) |-> (out_count == '0))
    else $error("echo result with nonzero count");

endmodule

`default_nettype wire
